FILE: hdl/abjq_pkg.sv
// Shared types and constants for the audio jitter buffer queue.
`timescale 1ns / 1ps
package abjq_pkg;

  localparam int SPEAKER_BPS     = 48000 * 2 * 2;
  localparam int MAX_QUEUED_RST  = SPEAKER_BPS * 400 / 1000;
  localparam int PREBUFFER_RST   = SPEAKER_BPS * 200 / 1000;

  localparam int TOTAL_W         = 24;
  localparam int TAG_W           = 16;
  localparam int LEN_W           = 16;
  localparam int KIND_W          = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int MAX_RESULTS     = 64;
  localparam int DROP_W          = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUEUED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREBUFFER  = 2'd1;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [KIND_W-1:0] KIND_OUT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DROP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd4;

  typedef struct packed {
    logic             op;
    logic [TAG_W-1:0] chunk_tag;
    logic [LEN_W-1:0] chunk_len;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TAG_W-1:0]   out_tag;
    logic [LEN_W-1:0]   out_len;
    logic               buffering;
    logic [TOTAL_W-1:0] total_bytes;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic              capture;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              pop;
    logic              push;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic len_zero;
    logic full;
    logic empty;
    logic prebuf;
    logic trim;
    logic drop_ok;
    logic emit_ok;
  } sts_t;

endpackage

FILE: hdl/audio_jitter_buffer_queue.sv
// Dequeue and empty-chunk items: the item is captured, its result is issued from dispatch, then idle.
// Enqueue: the chunk is written, then one drop result per oldest chunk trimmed, then a done result
// (at most 63 drops per item, a full-store drop included); a full store first emits a drop.
// One item at a time, paced by the single-read descriptor RAM; stalls hold the sequencer.
// Synchronous active-low reset: queue empty, prebuffering set, config registers to defaults,
// output register empty, descriptor RAM contents left as they are.
`timescale 1ns / 1ps
module audio_jitter_buffer_queue
  import abjq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOTAL_W-1:0]   cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  abjq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  abjq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/abjq_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module abjq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/abjq_ctrl.sv
// Sequencer for enqueue, trim and dequeue steps.
`timescale 1ns / 1ps
module abjq_ctrl
  import abjq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_WRITE    = 3'd2;
  localparam logic [2:0] S_TRIM     = 3'd3;
  localparam logic [2:0] S_SETTLE   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.op == OP_ENQ) begin
          if (sts.len_zero) begin
            if (sts.emit_ok) begin
              cmd.emit  = 1'b1;
              cmd.kind  = KIND_EMPTY;
              state_nxt = S_IDLE;
            end
          end else if (sts.full) begin
            if (sts.emit_ok) begin
              cmd.emit  = 1'b1;
              cmd.kind  = KIND_DROP;
              cmd.pop   = 1'b1;
              state_nxt = S_WRITE;
            end
          end else begin
            state_nxt = S_WRITE;
          end
        end else if (sts.prebuf || sts.empty) begin
          if (sts.emit_ok) begin
            cmd.emit  = 1'b1;
            cmd.kind  = KIND_NONE;
            state_nxt = S_IDLE;
          end
        end else if (sts.emit_ok) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_OUT;
          cmd.pop   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WRITE: begin
        cmd.push  = 1'b1;
        state_nxt = S_TRIM;
      end
      S_TRIM: begin
        if (sts.emit_ok) begin
          cmd.emit = 1'b1;
          if (sts.trim && sts.drop_ok) begin
            cmd.kind  = KIND_DROP;
            cmd.pop   = 1'b1;
            state_nxt = S_SETTLE;
          end else begin
            cmd.kind  = KIND_DONE;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SETTLE: begin
        // head moved, wait for the store read to catch up
        state_nxt = S_TRIM;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.emit_ok)
    else $error("result issued while output register is occupied");

  a_no_pop_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.pop && cmd.push))
    else $error("pop and push in the same cycle");

  a_capture_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_DISPATCH)
    else $error("captured item not dispatched");

endmodule

FILE: hdl/abjq_dp.sv
// Datapath: descriptor store, pointers, byte total, config and output register.
`timescale 1ns / 1ps
module abjq_dp
  import abjq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOTAL_W-1:0]   cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = TAG_W + LEN_W;

  logic [AW-1:0]      head_r, head_nxt, head_inc, tail;
  logic [CW-1:0]      count_r, count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt, total_sub, total_add;
  logic [TOTAL_W:0]   add_sum;
  logic [AW:0]        tail_sum, tail_wrap;
  logic               prebuf_r, prebuf_nxt;
  logic [TOTAL_W-1:0] max_r, pre_r;
  logic [DROP_W-1:0]  drops_r, drops_nxt;
  in_item_t           item_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic [DW-1:0]      rd_data;
  logic [TAG_W-1:0]   rd_tag;
  logic [LEN_W-1:0]   rd_len;
  logic               emit_ok;

  abjq_ram #(
    .WIDTH (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail),
    .wdata ({item_r.chunk_tag, item_r.chunk_len}),
    .raddr (head_r),
    .rdata (rd_data)
  );

  assign rd_tag = rd_data[DW-1:LEN_W];
  assign rd_len = rd_data[LEN_W-1:0];

  assign head_inc  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_sum  = {1'b0, head_r} + (AW+1)'(count_r);
  assign tail_wrap = tail_sum - (AW+1)'(QUEUE_DEPTH);
  assign tail      = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                     tail_wrap[AW-1:0] : tail_sum[AW-1:0];

  assign total_sub = (total_r >= TOTAL_W'(rd_len)) ? total_r - TOTAL_W'(rd_len) : '0;
  assign add_sum   = {1'b0, total_r} + (TOTAL_W+1)'(item_r.chunk_len);
  assign total_add = add_sum[TOTAL_W] ? '1 : add_sum[TOTAL_W-1:0];

  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    prebuf_nxt = prebuf_r;
    drops_nxt  = drops_r;
    if (cmd.capture) begin
      drops_nxt = '0;
    end
    if (cmd.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CW'(1);
      total_nxt = total_sub;
      if (cmd.kind == KIND_OUT && count_r == CW'(1)) begin
        prebuf_nxt = 1'b1;
      end
      if (cmd.kind == KIND_DROP) begin
        drops_nxt = drops_r + DROP_W'(1);
      end
    end else if (cmd.push) begin
      count_nxt = count_r + CW'(1);
      total_nxt = total_add;
    end
    if (cmd.emit && cmd.kind == KIND_DONE && total_r >= pre_r) begin
      prebuf_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (cmd.emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.kind        = cmd.kind;
      out_data_nxt.out_tag     = cmd.pop ? rd_tag : '0;
      out_data_nxt.out_len     = cmd.pop ? rd_len : '0;
      out_data_nxt.buffering   = prebuf_nxt;
      out_data_nxt.total_bytes = total_nxt;
      out_data_nxt.last        = (cmd.kind != KIND_DROP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      total_r     <= '0;
      prebuf_r    <= 1'b1;
      drops_r     <= '0;
      out_valid_r <= 1'b0;
      max_r       <= TOTAL_W'(MAX_QUEUED_RST);
      pre_r       <= TOTAL_W'(PREBUFFER_RST);
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      prebuf_r    <= prebuf_nxt;
      drops_r     <= drops_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_QUEUED: max_r <= cfg_wdata;
          CFG_PREBUFFER:  pre_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  always_comb begin
    sts.op       = item_r.op;
    sts.len_zero = (item_r.chunk_len == '0);
    sts.full     = (count_r == CW'(QUEUE_DEPTH));
    sts.empty    = (count_r == '0);
    sts.prebuf   = prebuf_r;
    sts.trim     = (total_r > max_r) && (count_r > CW'(1));
    sts.drop_ok  = (drops_r != DROP_W'(MAX_RESULTS - 1));
    sts.emit_ok  = emit_ok;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> total_r == '0)
    else $error("byte total left over in an empty queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> count_r != '0)
    else $error("pop from an empty queue");

endmodule
